// ===== rtl/sfd_pkg.sv =====
// Shared types, codes and sizes for the SLIP frame decoder.
`default_nettype none
package sfd_pkg;

    // SLIP framing characters
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // Sizes
    localparam int unsigned CFG_LEN_W         = 13;
    localparam int unsigned CFG_LEN_RESET     = 4096;
    localparam int unsigned MAX_FRAME_BYTES_D = 4096;
    localparam int unsigned TAIL_BYTES        = 4;
    localparam int unsigned SUM_W             = 32;
    localparam int unsigned QUEUE_DEPTH       = 2;
    localparam int unsigned QUEUE_PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } frame_status_t;

    // Kind of work handed from the front part to the back part
    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_END  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } slip_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/sfd_front.sv =====
// Front part: accepts link words, removes escapes and classifies them.
`default_nettype none
module sfd_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_fire,
    input  wire  [7:0]          link_byte,
    output logic                push,
    output sfd_pkg::slip_cmd_t  cmd
);
    import sfd_pkg::*;

    logic escape_reg;
    logic escape_next;

    // Decode the word against the escape state
    always_comb
    begin
        escape_next = escape_reg;
        push        = 1'b0;
        cmd.kind    = CMD_DATA;
        cmd.data    = link_byte;
        if (in_fire)
        begin
            if (escape_reg)
            begin
                escape_next = 1'b0;
                unique case (link_byte)
                    SLIP_ESC_END:
                    begin
                        push     = 1'b1;
                        cmd.data = SLIP_END;
                    end
                    SLIP_ESC_ESC:
                    begin
                        push     = 1'b1;
                        cmd.data = SLIP_ESC;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
            else
            begin
                unique case (link_byte)
                    SLIP_ESC:
                    begin
                        escape_next = 1'b1;
                    end
                    SLIP_END:
                    begin
                        push     = 1'b1;
                        cmd.kind = CMD_END;
                        cmd.data = 8'd0;
                    end
                    default:
                    begin
                        push = 1'b1;
                    end
                endcase
            end
        end
    end

    // Hold the escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            escape_reg <= 1'b0;
        else
            escape_reg <= escape_next;
    end

endmodule
`default_nettype wire

// ===== rtl/sfd_queue.sv =====
// Short command queue between the front and back parts.
`default_nettype none
module sfd_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  wire sfd_pkg::slip_cmd_t  push_cmd,
    output logic                     full,
    input  wire                      pop,
    output logic                     not_empty,
    output sfd_pkg::slip_cmd_t       head_cmd
);
    import sfd_pkg::*;

    slip_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

// ===== rtl/sfd_back.sv =====
// Back part: frame counting, sum check and the registered result stage.
`default_nettype none
module sfd_back #(
    parameter int unsigned MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_D
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire  [sfd_pkg::CFG_LEN_W-1:0]  frame_len_cfg,
    input  wire                            cmd_valid,
    input  wire sfd_pkg::slip_cmd_t        cmd,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [7:0]                     byte_value,
    output logic                           is_frame_end,
    output logic [1:0]                     frame_status
);
    import sfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned LIM_W = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] prefix_reg;
    logic [SUM_W-1:0] prefix_next;
    logic [SUM_W-1:0] tail_reg;
    logic [SUM_W-1:0] tail_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       byte_reg;
    logic             end_reg;
    frame_status_t    status_reg;
    logic             load_out;
    logic [7:0]       byte_out;
    logic             end_out;
    frame_status_t    status_out;
    logic [LIM_W-1:0] limit;
    logic             full_frame;

    // Clamp the configured length to the build maximum
    always_comb
    begin
        if (LIM_W'(frame_len_cfg) > LIM_W'(MAX_FRAME_BYTES))
            limit = LIM_W'(MAX_FRAME_BYTES);
        else
            limit = LIM_W'(frame_len_cfg);
    end

    assign full_frame = (LIM_W'(count_reg) >= limit);
    assign cmd_pop    = cmd_valid && (!out_valid_reg || out_ready);

    // Frame state and result selection. The prefix register holds the sum of
    // all bytes that have left the four-byte tail window, so it equals the
    // running sum minus the tail bytes.
    always_comb
    begin
        count_next  = count_reg;
        prefix_next = prefix_reg;
        tail_next   = tail_reg;
        ovf_next    = ovf_reg;
        load_out    = 1'b0;
        byte_out    = cmd.data;
        end_out     = 1'b0;
        status_out  = ST_OK;
        if (cmd_pop)
        begin
            unique case (cmd.kind)
                CMD_DATA:
                begin
                    if (full_frame)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        load_out    = 1'b1;
                        count_next  = count_reg + 1'b1;
                        prefix_next = prefix_reg + SUM_W'(tail_reg[7:0]);
                        tail_next   = {cmd.data, tail_reg[SUM_W-1:8]};
                    end
                end
                CMD_END:
                begin
                    load_out = 1'b1;
                    byte_out = 8'd0;
                    end_out  = 1'b1;
                    if (ovf_reg)
                        status_out = ST_OVERFLOW;
                    else if (count_reg < CNT_W'(TAIL_BYTES))
                        status_out = ST_SHORT;
                    else if (prefix_reg == tail_reg)
                        status_out = ST_OK;
                    else
                        status_out = ST_MISMATCH;
                    count_next  = '0;
                    prefix_next = '0;
                    tail_next   = '0;
                    ovf_next    = 1'b0;
                end
                default:
                begin
                    load_out = 1'b0;
                end
            endcase
        end
    end

    // Output register: load a new result or drop the taken one
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prefix_reg    <= '0;
            tail_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            prefix_reg    <= prefix_next;
            tail_reg      <= tail_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            byte_reg   <= byte_out;
            end_reg    <= end_out;
            status_reg <= status_out;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_value   = byte_reg;
    assign is_frame_end = end_reg;
    assign frame_status = status_reg;

endmodule
`default_nettype wire

// ===== rtl/slip_frame_decoder_with_sum_check.sv =====
// Top level of the SLIP frame decoder with trailing sum check.
`default_nettype none
// Takes one raw link word per cycle while in_ready is high and removes
// SLIP framing. Each decoded byte comes out as a data result; END gives a
// frame-end result whose status is ok, checksum mismatch (last four bytes,
// little-endian, differ from the sum of the earlier bytes), too short (under
// four bytes) or overflow (bytes beyond max_frame_len were dropped; this
// wins over the others). Words that yield no result (ESC, a bad escape pair,
// overflow drops) are still accepted. The front decoder writes a two-entry
// command queue at the accepting edge; when the output register is free or
// being taken, the back part pops the queue head, updates the frame state
// and loads the output register. in_ready drops only when that queue is full.
// max_frame_len may be written only while the block is idle; cfg_ready is
// always high.
module slip_frame_decoder_with_sum_check #(
    parameter int unsigned MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_D
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [sfd_pkg::CFG_LEN_W-1:0]  max_frame_len,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [7:0]                     link_byte,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [7:0]                     byte_value,
    output logic                           is_frame_end,
    output logic [1:0]                     frame_status
);
    import sfd_pkg::*;

    logic [CFG_LEN_W-1:0] frame_len_reg;
    logic                 in_fire;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;
    slip_cmd_t            front_cmd;
    slip_cmd_t            head_cmd;

    // Hold the frame length register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_len_reg <= CFG_LEN_W'(CFG_LEN_RESET);
        else if (cfg_valid && cfg_ready)
            frame_len_reg <= max_frame_len;
    end

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    sfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .link_byte (link_byte),
        .push      (q_push),
        .cmd       (front_cmd)
    );

    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    sfd_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_len_cfg (frame_len_reg),
        .cmd_valid     (q_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_value    (byte_value),
        .is_frame_end  (is_frame_end),
        .frame_status  (frame_status)
    );

`ifndef NO_ASSERTIONS
    // Never push into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into full queue");

    // Never pop an empty queue
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("command popped from empty queue");

    // Frame-end results carry a zero byte
    a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_frame_end) |-> (byte_value == 8'd0))
        else $error("frame-end result with nonzero byte");

    // Data results carry ok status
    a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_frame_end) |-> (frame_status == ST_OK))
        else $error("data result with nonzero status");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/slip_frame_decoder_with_sum_check_checker.sv =====
// Checker for the SLIP frame decoder: tracks frame state, predicts each result and compares it.
module slip_frame_decoder_with_sum_check_checker
    import sfd_pkg::*;
#(
    parameter int unsigned CAP_BYTES = MAX_FRAME_BYTES_D
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_valid,
    input  wire                  cfg_ready,
    input  wire  [CFG_LEN_W-1:0] max_frame_len,
    input  wire                  in_valid,
    input  wire                  in_ready,
    input  wire  [7:0]           link_byte,
    input  wire                  out_valid,
    input  wire                  out_ready,
    input  wire  [7:0]           byte_value,
    input  wire                  is_frame_end,
    input  wire  [1:0]           frame_status,
    output int                   mismatch_count,
    output int                   results_pending,
    output int                   results_checked,
    output int                   frame_ends_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]    value;
        logic          frame_end;
        frame_status_t status;
    } decoded_word_t;

    decoded_word_t expected_q[$];

    // Shadow copy of the decoder's register and frame state
    logic [CFG_LEN_W-1:0] len_limit;
    logic                 esc_seen;
    logic [CFG_LEN_W-1:0] frame_bytes;
    logic [31:0]          frame_total;
    logic [31:0]          tail_word;
    logic                 frame_overflowed;

    function automatic logic [CFG_LEN_W-1:0] active_limit();
        return (len_limit > CAP_BYTES) ? CFG_LEN_W'(CAP_BYTES) : len_limit;
    endfunction

    task automatic clear_frame();
        esc_seen = 1'b0;
        frame_bytes = '0;
        frame_total = '0;
        tail_word = '0;
        frame_overflowed = 1'b0;
    endtask

    // Count, sum and emit one decoded byte, or drop it once the frame is full
    task automatic take_payload(input logic [7:0] b);
        decoded_word_t w;
        if (frame_bytes >= active_limit())
        begin
            frame_overflowed = 1'b1;
        end
        else
        begin
            frame_bytes = frame_bytes + 1'b1;
            frame_total = frame_total + 32'(b);
            tail_word = {b, tail_word[31:8]};
            w.value = b;
            w.frame_end = 1'b0;
            w.status = ST_OK;
            expected_q.push_back(w);
        end
    endtask

    // Grade the frame on END: overflow wins, then too short, then the sum test
    task automatic close_frame();
        logic [31:0]   tail_total;
        decoded_word_t w;
        tail_total = 32'(tail_word[7:0]) + 32'(tail_word[15:8])
                   + 32'(tail_word[23:16]) + 32'(tail_word[31:24]);
        if (frame_overflowed)
            w.status = ST_OVERFLOW;
        else if (frame_bytes < TAIL_BYTES)
            w.status = ST_SHORT;
        else if (frame_total - tail_total == tail_word)
            w.status = ST_OK;
        else
            w.status = ST_MISMATCH;
        w.value = '0;
        w.frame_end = 1'b1;
        expected_q.push_back(w);
        clear_frame();
    endtask

    // Undo SLIP framing for one link word; a bad escape pair drops both words
    task automatic decode_link_word(input logic [7:0] b);
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (b == SLIP_ESC_END)
                take_payload(SLIP_END);
            else if (b == SLIP_ESC_ESC)
                take_payload(SLIP_ESC);
        end
        else if (b == SLIP_ESC)
        begin
            esc_seen = 1'b1;
        end
        else if (b == SLIP_END)
        begin
            close_frame();
        end
        else
        begin
            take_payload(b);
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        decoded_word_t exp_w;
        decoded_word_t got_w;
        got_w.value = byte_value;
        got_w.frame_end = is_frame_end;
        got_w.status = frame_status_t'(frame_status);
        if (expected_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: byte %02h end %0b status %0d",
                         got_w.value, got_w.frame_end, got_w.status);
        end
        else
        begin
            exp_w = expected_q.pop_front();
            results_checked++;
            if (exp_w.frame_end)
                frame_ends_checked++;
            if (got_w.value !== exp_w.value || got_w.frame_end !== exp_w.frame_end
                || got_w.status !== exp_w.status)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d: expected byte %02h end %0b status %0d, got byte %02h end %0b status %0d",
                             results_checked, exp_w.value, exp_w.frame_end, exp_w.status,
                             got_w.value, got_w.frame_end, got_w.status);
            end
        end
    endtask

    // Watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_limit = CFG_LEN_W'(CFG_LEN_RESET);
            clear_frame();
            expected_q.delete();
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                len_limit = max_frame_len;
            if (in_valid && in_ready)
                decode_link_word(link_byte);
            if (out_valid && out_ready)
                check_result();
            results_pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_slip_frame_decoder_with_sum_check.sv =====
// Testbench top for the SLIP frame decoder: stimulus, stalls, limit writes and verdict.
module tb_slip_frame_decoder_with_sum_check;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_LEN_W-1:0] max_frame_len = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           link_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           byte_value;
    logic                 is_frame_end;
    logic [1:0]           frame_status;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;
    int cycle_count = 0;
    int mismatch_count;
    int results_pending;
    int results_checked;
    int frame_ends_checked;

    // Empty frame, short frame, both escapes plus bad escapes in a good frame, sum mismatch
    logic [7:0] directed_words [23] = '{
        SLIP_END,
        8'h00, 8'hFF, SLIP_END,
        SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC, SLIP_ESC, 8'h41, SLIP_ESC, SLIP_END,
        8'h9B, 8'h01, 8'h00, 8'h00, SLIP_END,
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, SLIP_END
    };

    slip_frame_decoder_with_sum_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .max_frame_len (max_frame_len),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .link_byte     (link_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_value    (byte_value),
        .is_frame_end  (is_frame_end),
        .frame_status  (frame_status)
    );

    slip_frame_decoder_with_sum_check_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .max_frame_len      (max_frame_len),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .link_byte          (link_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .byte_value         (byte_value),
        .is_frame_end       (is_frame_end),
        .frame_status       (frame_status),
        .mismatch_count     (mismatch_count),
        .results_pending    (results_pending),
        .results_checked    (results_checked),
        .frame_ends_checked (frame_ends_checked)
    );

    always #2 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[slip_frame_decoder_with_sum_check] ERROR");
            $finish;
        end
    end

    // Offer one link word, with random gaps ahead of it, and hold until accepted
    task automatic push_link_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        link_byte <= b;
        words_sent++;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Escape a decoded byte onto the link
    task automatic push_decoded_byte(input logic [7:0] b);
        case (b)
            SLIP_END:
            begin
                push_link_word(SLIP_ESC);
                push_link_word(SLIP_ESC_END);
            end
            SLIP_ESC:
            begin
                push_link_word(SLIP_ESC);
                push_link_word(SLIP_ESC_ESC);
            end
            default:
                push_link_word(b);
        endcase
    endtask

    // Payload bytes lean toward the framing characters
    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(11))
            0: return SLIP_END;
            1: return SLIP_ESC;
            2: return SLIP_ESC_END;
            3: return SLIP_ESC_ESC;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Payload followed by its sum, little-endian; optionally flip one bit
    task automatic send_checked_frame(input int payload_len, input bit corrupt);
        logic [7:0]  frame_q[$];
        logic [31:0] frame_total;
        int          pick;
        frame_total = '0;
        for (int i = 0; i < payload_len; i++)
        begin
            frame_q.push_back(pick_payload_byte());
            frame_total = frame_total + 32'(frame_q[i]);
        end
        for (int k = 0; k < TAIL_BYTES; k++)
        begin
            frame_q.push_back(frame_total[8*k +: 8]);
        end
        if (corrupt)
        begin
            pick = $urandom_range(frame_q.size() - 1);
            frame_q[pick] = frame_q[pick] ^ (8'h01 << $urandom_range(7));
        end
        foreach (frame_q[i])
        begin
            push_decoded_byte(frame_q[i]);
        end
        push_link_word(SLIP_END);
    endtask

    task automatic send_short_frame();
        int n;
        n = $urandom_range(3);
        repeat (n)
        begin
            push_decoded_byte(pick_payload_byte());
        end
        push_link_word(SLIP_END);
    endtask

    // Raw words with loose escapes, stray escape codes and ENDs
    task automatic send_noise_frame();
        int n;
        n = $urandom_range(12, 1);
        repeat (n)
        begin
            case ($urandom_range(7))
                0: push_link_word(SLIP_ESC);
                1: push_link_word(SLIP_ESC_END);
                2: push_link_word(SLIP_ESC_ESC);
                default: push_link_word(8'($urandom_range(255)));
            endcase
        end
        push_link_word(SLIP_END);
    endtask

    task automatic send_random_frames(input int word_goal);
        int stop_at;
        int kind;
        stop_at = words_sent + word_goal;
        while (words_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
                send_checked_frame($urandom_range(16), $urandom_range(99) < 20);
            else if (kind < 85)
                send_short_frame();
            else
                send_noise_frame();
        end
    endtask

    // Drop valid, drain all results and let the pipeline empty
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_limit(input logic [CFG_LEN_W-1:0] v);
        cfg_valid <= 1'b1;
        max_frame_len <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver heavily; reset limit, then a limit of four
        send_idle_pct <= 19;
        recv_idle_pct <= 47;
        foreach (directed_words[i])
        begin
            push_link_word(directed_words[i]);
        end
        send_random_frames(300);
        settle_block();
        write_frame_limit(13'd4);
        send_random_frames(280);
        settle_block();

        // Swap the stall rates; a zero limit, then a small one
        send_idle_pct <= 47;
        recv_idle_pct <= 19;
        write_frame_limit(13'd0);
        send_random_frames(150);
        settle_block();
        write_frame_limit(13'd12);
        send_random_frames(450);
        settle_block();

        // No stalls; an oversized limit is held to the build cap
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_frame_limit(13'h1FFF);
        send_random_frames(250);
        settle_block();
        write_frame_limit(13'(CFG_LEN_RESET));
        send_random_frames(300);
        settle_block();

        $display("Run covered %0d link words and checked %0d results, %0d of them frame ends.",
                 words_sent, results_checked, frame_ends_checked);
        $display("Frame limits 4096, 4, 0, 12, 8191 (held to the cap) and 4096 again, %s",
                 "under both stall mixes and none.");
        if (mismatch_count == 0 && results_pending == 0)
            $display("[slip_frame_decoder_with_sum_check] OK");
        else
            $display("[slip_frame_decoder_with_sum_check] ERROR");
        $finish;
    end

endmodule
